// ----- design/lzwd_pkg.sv -----
package lzwd_pkg;

   // Window store depth; a power of two from 2048 to 4096.
   localparam int WINDOW_DEPTH = 4096;
   localparam int WIN_AW       = $clog2(WINDOW_DEPTH);

   // Ring size for each length field width, capped at the store depth.
   localparam int WIN_N_LB4 = (WINDOW_DEPTH < 4096) ? WINDOW_DEPTH : 4096;
   localparam int WIN_N_LB5 = (WINDOW_DEPTH < 2048) ? WINDOW_DEPTH : 2048;

   // First write position after a clear: N - 2^length_bits - 2.
   localparam int START_LB4 = WIN_N_LB4 - 16 - 2;
   localparam int START_LB5 = WIN_N_LB5 - 32 - 2;

   // Longest copy is 31 + 3 bytes; the down counter holds length minus one.
   localparam int MAX_COPY_REM = 33;

   // Configuration register indexes.
   localparam logic CSR_LENGTH_BITS  = 1'b0;
   localparam logic CSR_OUTPUT_LIMIT = 1'b1;

   typedef logic [WIN_AW-1:0] win_addr_type;
   typedef logic [31:0]       count_type;

   // Index mask of the ring for the effective length field width.
   function automatic win_addr_type win_mask(input logic lb5);
      win_mask = lb5 ? win_addr_type'(WIN_N_LB5 - 1) : win_addr_type'(WIN_N_LB4 - 1);
   endfunction

   function automatic win_addr_type start_position(input logic lb5);
      start_position = lb5 ? win_addr_type'(START_LB5) : win_addr_type'(START_LB4);
   endfunction

endpackage

// ----- design/lzss_window_decoder.sv -----
// A flag byte, the low byte of a reference or an ignored byte gives its single status result
//   from S_STATUS; a literal gives its byte from S_LIT, both after S_DECODE has classified it.
// A new code byte is taken only in S_IDLE, once the last one is done; the byte that ends a
//   reference of L bytes does one window read and one write-back per copied byte.
// A byte with stream_start first sweeps all WINDOW_DEPTH (4096) window entries to zero.
// Reset (synchronous, active high) restores length_bits 4 and output_limit all ones, then
//   sweeps the window to zero with req_tready low.
module lzss_window_decoder
   import lzwd_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   // code stream in
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [7:0]  req_tdata,   // [7:0] code_byte
   input  logic        req_tuser,   // [0] stream_start
   input  logic        req_tlast,   // stream_end
   // decoded stream out
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [39:0] rsp_tdata,   // [7:0] text_byte, [39:8] bytes_written
   output logic [1:0]  rsp_tuser,   // [0] data_valid, [1] stream_done
   output logic        rsp_tlast,   // run_last
   // register writes
   input  logic        csr_valid,
   output logic        csr_ready,
   input  logic        csr_index,
   input  logic [31:0] csr_data
);

   // Sequencer states
   localparam logic [2:0] S_IDLE   = 3'd0;  // take a code byte
   localparam logic [2:0] S_CLEAR  = 3'd1;  // sweep window to zero
   localparam logic [2:0] S_DECODE = 3'd2;  // classify the byte, update flags
   localparam logic [2:0] S_STATUS = 3'd3;  // send the single status result
   localparam logic [2:0] S_LIT    = 3'd4;  // send a literal
   localparam logic [2:0] S_READ   = 3'd5;  // issue one window read of a copy
   localparam logic [2:0] S_DATA   = 3'd6;  // send the copied byte, write it back

   // Decode phases
   localparam logic [1:0] PH_FLAG = 2'd0;
   localparam logic [1:0] PH_UNIT = 2'd1;
   localparam logic [1:0] PH_HIGH = 2'd2;

   logic [2:0]   state_ff, state_in;
   logic [2:0]   length_bits_ff, length_bits_in;
   count_type    limit_ff, limit_in;
   win_addr_type wp_ff, wp_in;
   logic [8:0]   flag_ff, flag_in;
   logic [1:0]   phase_ff, phase_in;
   logic [7:0]   held_ff, held_in;
   count_type    cnt_ff, cnt_in;
   logic         limit_hit_ff, limit_hit_in;
   win_addr_type clr_ff, clr_in;
   logic         clr_item_ff, clr_item_in;

   // latched code byte
   logic [7:0]   byte_ff, byte_in;
   logic         se_ff, se_in;

   // copy sequencing
   win_addr_type copy_addr_ff, copy_addr_in;
   logic [5:0]   rem_ff, rem_in;

   // output register
   logic         rsp_valid_ff, rsp_valid_in;
   logic [7:0]   rsp_text_ff, rsp_text_in;
   logic         rsp_dv_ff, rsp_dv_in;
   logic         rsp_last_ff, rsp_last_in;
   logic         rsp_done_ff, rsp_done_in;
   count_type    rsp_bytes_ff, rsp_bytes_in;

   logic         req_xfer, rsp_xfer, slot_free, rsp_load;
   logic         lb5;
   win_addr_type mask;
   logic         ram_we, ram_re;
   win_addr_type ram_waddr;
   logic [7:0]   ram_wdata, ram_rdata;

   logic         lh_now, emit_en;
   count_type    cnt_inc;
   logic         lh_after;
   logic [8:0]   flag_shifted;
   logic [11:0]  off_full;
   logic [3:0]   off_high;
   logic [5:0]   len_field;

   assign req_tready = (state_ff == S_IDLE);
   assign req_xfer   = req_tvalid && req_tready;
   assign csr_ready  = (state_ff == S_IDLE);
   assign rsp_xfer   = rsp_valid_ff && rsp_tready;
   assign slot_free  = !rsp_valid_ff || rsp_tready;

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = {rsp_bytes_ff, rsp_text_ff};
   assign rsp_tuser  = {rsp_done_ff, rsp_dv_ff};
   assign rsp_tlast  = rsp_last_ff;

   // length_bits below 4 acts as 4, above 5 as 5
   assign lb5  = (length_bits_ff >= 3'd5);
   assign mask = win_mask(lb5);

   assign lh_now       = limit_hit_ff || (cnt_ff >= limit_ff);
   assign cnt_inc      = cnt_ff + 32'd1;
   assign lh_after     = (cnt_inc >= limit_ff);
   assign flag_shifted = {1'b0, flag_ff[8:1]};

   // reference fields of the high byte
   assign off_high  = lb5 ? {1'b0, byte_ff[7:5]} : byte_ff[7:4];
   assign off_full  = {off_high, held_ff};
   assign len_field = lb5 ? {1'b0, byte_ff[4:0]} : {2'b00, byte_ff[3:0]};

   always_comb begin
      state_in       = state_ff;
      length_bits_in = length_bits_ff;
      limit_in       = limit_ff;
      wp_in          = wp_ff;
      flag_in        = flag_ff;
      phase_in       = phase_ff;
      held_in        = held_ff;
      cnt_in         = cnt_ff;
      limit_hit_in   = limit_hit_ff;
      clr_in         = clr_ff;
      clr_item_in    = clr_item_ff;
      byte_in        = byte_ff;
      se_in          = se_ff;
      copy_addr_in   = copy_addr_ff;
      rem_in         = rem_ff;

      rsp_load     = 1'b0;
      rsp_text_in  = rsp_text_ff;
      rsp_dv_in    = rsp_dv_ff;
      rsp_last_in  = rsp_last_ff;
      rsp_done_in  = rsp_done_ff;
      rsp_bytes_in = rsp_bytes_ff;

      ram_we    = 1'b0;
      ram_waddr = wp_ff & mask;
      ram_wdata = byte_ff;
      ram_re    = 1'b0;
      emit_en   = 1'b0;

      // registers are written only while idle
      if (csr_valid && csr_ready) begin
         unique case (csr_index)
            CSR_LENGTH_BITS:  length_bits_in = csr_data[2:0];
            CSR_OUTPUT_LIMIT: limit_in       = csr_data;
            default:          limit_in       = limit_ff;
         endcase
      end

      unique case (state_ff)
         S_IDLE: begin
            if (req_xfer) begin
               byte_in = req_tdata;
               se_in   = req_tlast;
               if (req_tuser) begin
                  // restart the stream, then sweep before decoding this byte
                  wp_in        = start_position(lb5);
                  flag_in      = '0;
                  phase_in     = PH_FLAG;
                  held_in      = '0;
                  cnt_in       = '0;
                  limit_hit_in = 1'b0;
                  clr_in       = '0;
                  clr_item_in  = 1'b1;
                  state_in     = S_CLEAR;
               end else begin
                  state_in = S_DECODE;
               end
            end
         end

         S_CLEAR: begin
            ram_we    = 1'b1;
            ram_waddr = clr_ff;
            ram_wdata = '0;
            clr_in    = clr_ff + win_addr_type'(1);
            if (clr_ff == win_addr_type'(WINDOW_DEPTH - 1)) begin
               clr_item_in = 1'b0;
               state_in    = clr_item_ff ? S_DECODE : S_IDLE;
            end
         end

         S_DECODE: begin
            limit_hit_in = lh_now;
            state_in     = S_STATUS;
            if (!lh_now) begin
               priority if (phase_ff == PH_FLAG || flag_ff <= 9'd1) begin
                  flag_in  = {1'b1, byte_ff};
                  phase_in = PH_UNIT;
               end else if (phase_ff == PH_UNIT) begin
                  if (flag_ff[0]) begin
                     state_in = S_LIT;
                  end else begin
                     held_in  = byte_ff;
                     phase_in = PH_HIGH;
                  end
               end else begin
                  copy_addr_in = win_addr_type'(off_full) & mask;
                  rem_in       = len_field + 6'd2;
                  state_in     = S_READ;
               end
            end
         end

         S_STATUS: begin
            if (slot_free) begin
               rsp_load     = 1'b1;
               rsp_text_in  = '0;
               rsp_dv_in    = 1'b0;
               rsp_last_in  = 1'b1;
               rsp_done_in  = se_ff || limit_hit_ff;
               rsp_bytes_in = cnt_ff;
               if (se_ff) begin
                  flag_in  = '0;
                  phase_in = PH_FLAG;
                  held_in  = '0;
               end
               state_in = S_IDLE;
            end
         end

         S_LIT: begin
            if (slot_free) begin
               emit_en      = 1'b1;
               ram_wdata    = byte_ff;
               rsp_last_in  = 1'b1;
               // finish the unit
               flag_in      = flag_shifted;
               phase_in     = (flag_shifted <= 9'd1) ? PH_FLAG : PH_UNIT;
               if (se_ff) begin
                  flag_in  = '0;
                  phase_in = PH_FLAG;
                  held_in  = '0;
               end
               state_in = S_IDLE;
            end
         end

         S_READ: begin
            ram_re   = 1'b1;
            state_in = S_DATA;
         end

         S_DATA: begin
            if (slot_free) begin
               emit_en     = 1'b1;
               ram_wdata   = ram_rdata;
               // last byte of the copy, or the limit stops the copy here
               rsp_last_in = (rem_ff == 6'd0) || lh_after;
               if (rem_ff == 6'd0) begin
                  flag_in  = flag_shifted;
                  phase_in = (flag_shifted <= 9'd1) ? PH_FLAG : PH_UNIT;
               end
               if (rem_ff == 6'd0 || lh_after) begin
                  if (se_ff) begin
                     flag_in  = '0;
                     phase_in = PH_FLAG;
                     held_in  = '0;
                  end
                  state_in = S_IDLE;
               end else begin
                  rem_in       = rem_ff - 6'd1;
                  copy_addr_in = (copy_addr_ff + win_addr_type'(1)) & mask;
                  state_in     = S_READ;
               end
            end
         end

         default: begin
            state_in = S_IDLE;
         end
      endcase

      // one decoded byte: write it back, advance position and count
      if (emit_en) begin
         ram_we       = 1'b1;
         wp_in        = (wp_ff + win_addr_type'(1)) & mask;
         cnt_in       = cnt_inc;
         limit_hit_in = lh_after;
         rsp_load     = 1'b1;
         rsp_text_in  = ram_wdata;
         rsp_dv_in    = 1'b1;
         rsp_done_in  = se_ff || lh_after;
         rsp_bytes_in = cnt_inc;
      end

      priority if (rsp_load) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_xfer) begin
         rsp_valid_in = 1'b0;
      end else begin
         rsp_valid_in = rsp_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff       <= S_CLEAR;
         length_bits_ff <= 3'd4;
         limit_ff       <= '1;
         wp_ff          <= start_position(1'b0);
         flag_ff        <= '0;
         phase_ff       <= PH_FLAG;
         held_ff        <= '0;
         cnt_ff         <= '0;
         limit_hit_ff   <= 1'b0;
         clr_ff         <= '0;
         clr_item_ff    <= 1'b0;
         rsp_valid_ff   <= 1'b0;
      end else begin
         state_ff       <= state_in;
         length_bits_ff <= length_bits_in;
         limit_ff       <= limit_in;
         wp_ff          <= wp_in;
         flag_ff        <= flag_in;
         phase_ff       <= phase_in;
         held_ff        <= held_in;
         cnt_ff         <= cnt_in;
         limit_hit_ff   <= limit_hit_in;
         clr_ff         <= clr_in;
         clr_item_ff    <= clr_item_in;
         rsp_valid_ff   <= rsp_valid_in;
      end
   end

   // payload: held by the enables above, no reset
   always_ff @(posedge clock) begin
      byte_ff      <= byte_in;
      se_ff        <= se_in;
      copy_addr_ff <= copy_addr_in;
      rem_ff       <= rem_in;
      rsp_text_ff  <= rsp_text_in;
      rsp_dv_ff    <= rsp_dv_in;
      rsp_last_ff  <= rsp_last_in;
      rsp_done_ff  <= rsp_done_in;
      rsp_bytes_ff <= rsp_bytes_in;
   end

   lzwd_window_ram #(
      .ADDR_WIDTH (WIN_AW),
      .DATA_WIDTH (8)
   ) u_window (
      .clock   (clock),
      .wr_en   (ram_we),
      .wr_addr (ram_waddr),
      .wr_data (ram_wdata),
      .rd_en   (ram_re),
      .rd_addr (copy_addr_ff),
      .rd_data (ram_rdata)
   );

`ifndef SYNTHESIS
   // limit stays hit until a new stream starts
   a_limit_sticky: assert property (@(posedge clock) disable iff (reset)
      limit_hit_ff && !(req_xfer && req_tuser) |=> limit_hit_ff)
      else $error("limit_hit dropped inside a stream");

   // a byte is only emitted below the limit
   a_emit_below_limit: assert property (@(posedge clock) disable iff (reset)
      emit_en |-> (cnt_ff < limit_ff))
      else $error("byte emitted at or past output_limit");

   // a data result always counts itself
   a_data_counted: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && rsp_tuser[0] |-> (rsp_tdata[39:8] != 32'd0))
      else $error("data result with zero byte count");

   // copy length stays within the longest reference
   a_copy_len: assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_READ) |-> (rem_ff <= 6'(MAX_COPY_REM)))
      else $error("copy counter out of range");
`endif

endmodule

// ----- design/lzwd_window_ram.sv -----
module lzwd_window_ram #(
   parameter int ADDR_WIDTH = 12,
   parameter int DATA_WIDTH = 8
) (
   input  logic                  clock,
   input  logic                  wr_en,
   input  logic [ADDR_WIDTH-1:0] wr_addr,
   input  logic [DATA_WIDTH-1:0] wr_data,
   input  logic                  rd_en,
   input  logic [ADDR_WIDTH-1:0] rd_addr,
   output logic [DATA_WIDTH-1:0] rd_data
);

   localparam int Depth = 1 << ADDR_WIDTH;

   logic [DATA_WIDTH-1:0] mem [Depth];
   logic [DATA_WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
   end

   always_ff @(posedge clock) begin
      if (rd_en) begin
         rd_data_ff <= mem[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

// ----- sim/testbench.sv -----
`timescale 1ns / 100ps

module testbench;
   import lzwd_pkg::*;

   localparam int MAX_TEXT_PER_CODE = 35;

   typedef enum logic [1:0] {
      EXPECT_FLAG,
      EXPECT_UNIT,
      EXPECT_HIGH
   } decode_phase_type;

   typedef struct packed {
      logic [7:0]  code;
      bit          ss;
      bit          se;
   } code_item_type;

   typedef struct packed {
      logic [7:0]  text_byte;
      logic        data_valid;
      logic        run_last;
      logic        stream_done;
      logic [31:0] bytes_written;
   } text_result_type;

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        req_tvalid = 1'b0;
   logic        req_tready;
   logic [7:0]  req_tdata = '0;
   logic        req_tuser = 1'b0;
   logic        req_tlast = 1'b0;
   logic        rsp_tvalid;
   logic        rsp_tready = 1'b0;
   logic [39:0] rsp_tdata;
   logic [1:0]  rsp_tuser;
   logic        rsp_tlast;
   logic        csr_valid = 1'b0;
   logic        csr_ready;
   logic        csr_index = CSR_LENGTH_BITS;
   logic [31:0] csr_data = '0;

   // register copies as the decoder sees them
   logic [2:0]       len_bits_cfg;
   logic [31:0]      out_limit;

   // decoder state mirror
   logic [7:0]       ring [WINDOW_DEPTH];
   int unsigned      ring_wr;
   logic [8:0]       flags;
   decode_phase_type phase;
   logic [7:0]       off_low;
   logic [31:0]      emitted;
   bit               stopped;

   text_result_type  step_out[$];
   text_result_type  expected_text[$];
   code_item_type    pending_codes[$];
   code_item_type    next_code;

   int unsigned      items_pushed = 0;
   int unsigned      items_taken = 0;
   int unsigned      mismatches = 0;
   int unsigned      send_idle_pct = 0;
   int unsigned      recv_stall_pct = 0;

   // stream generator bookkeeping: rough guess of where text lands in the ring
   int unsigned      gen_base;
   int unsigned      gen_made;

   always begin
      #2 clock = 1'b1;
      #2 clock = 1'b0;
   end

   lzss_window_decoder DUT (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .req_tlast  (req_tlast),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser),
      .rsp_tlast  (rsp_tlast),
      .csr_valid  (csr_valid),
      .csr_ready  (csr_ready),
      .csr_index  (csr_index),
      .csr_data   (csr_data)
   );

   // Clamp the length field width to the two supported sizes.
   function automatic int unsigned eff_len_bits(logic [2:0] lb);
      if (lb < 3'd4) return 4;
      if (lb > 3'd5) return 5;
      return lb;
   endfunction

   function automatic int unsigned ring_size(logic [2:0] lb);
      int unsigned n;
      n = 1 << (16 - eff_len_bits(lb));
      if (n > WINDOW_DEPTH) n = WINDOW_DEPTH;
      return n;
   endfunction

   function automatic void clear_stream_model();
      int unsigned n;
      int unsigned f;
      n = ring_size(len_bits_cfg);
      f = 1 << eff_len_bits(len_bits_cfg);
      foreach (ring[i]) ring[i] = 8'h00;
      ring_wr = (n - f - 2) & (n - 1);
      flags   = '0;
      phase   = EXPECT_FLAG;
      off_low = '0;
      emitted = '0;
      stopped = 1'b0;
   endfunction

   function automatic void advance_unit();
      flags = flags >> 1;
      phase = (flags <= 9'd1) ? EXPECT_FLAG : EXPECT_UNIT;
   endfunction

   // Emit one text byte unless the limit has stopped output.
   function automatic bit emit_text(logic [7:0] ch, bit se, int unsigned n);
      text_result_type r;
      if (stopped) return 1'b0;
      if (emitted >= out_limit) begin
         stopped = 1'b1;
         return 1'b0;
      end
      if (step_out.size() >= MAX_TEXT_PER_CODE) return 1'b0;
      ring[ring_wr & (n - 1)] = ch;
      ring_wr = (ring_wr + 1) & (n - 1);
      emitted = emitted + 1;
      if (emitted >= out_limit) stopped = 1'b1;
      r.text_byte     = ch;
      r.data_valid    = 1'b1;
      r.run_last      = 1'b0;
      r.stream_done   = se || stopped;
      r.bytes_written = emitted;
      step_out.push_back(r);
      return 1'b1;
   endfunction

   // Work out the text results of one accepted code byte.
   function automatic void predict_text(logic [7:0] code, bit ss, bit se);
      int unsigned     n;
      int unsigned     lb;
      int unsigned     off;
      int unsigned     cnt;
      int unsigned     i;
      bit              ok;
      text_result_type r;
      if (ss) clear_stream_model();
      n  = ring_size(len_bits_cfg);
      lb = eff_len_bits(len_bits_cfg);
      if (!stopped && emitted >= out_limit) stopped = 1'b1;
      step_out.delete();
      if (!stopped) begin
         if (phase == EXPECT_FLAG || flags <= 9'd1) begin
            flags = {1'b1, code};
            phase = EXPECT_UNIT;
         end else if (phase == EXPECT_UNIT) begin
            if (flags[0]) begin
               if (emit_text(code, se, n)) advance_unit();
            end else begin
               off_low = code;
               phase   = EXPECT_HIGH;
            end
         end else begin
            off = int'(off_low) | ((int'(code) >> lb) << 8);
            cnt = (int'(code) & ((1 << lb) - 1)) + 3;
            ok  = 1'b1;
            for (i = 0; i < cnt && ok; i++) begin
               ok = emit_text(ring[(off + i) & (n - 1)], se, n);
            end
            if (ok) advance_unit();
         end
      end
      if (se) begin
         flags   = '0;
         phase   = EXPECT_FLAG;
         off_low = '0;
      end
      if (step_out.size() == 0) begin
         r               = '0;
         r.stream_done   = se || stopped;
         r.bytes_written = emitted;
      end else begin
         r = step_out.pop_back();
      end
      r.run_last = 1'b1;
      step_out.push_back(r);
      foreach (step_out[k]) expected_text.push_back(step_out[k]);
   endfunction

   function automatic void check_text();
      text_result_type want;
      if (expected_text.size() == 0) begin
         $error("text transfer with nothing expected: tdata %h tuser %b tlast %b",
                rsp_tdata, rsp_tuser, rsp_tlast);
         mismatches++;
         return;
      end
      want = expected_text.pop_front();
      if (rsp_tdata[7:0] !== want.text_byte) begin
         $error("text_byte: expected %0h, got %0h", want.text_byte, rsp_tdata[7:0]);
         mismatches++;
      end
      if (rsp_tuser[0] !== want.data_valid) begin
         $error("data_valid: expected %0b, got %0b", want.data_valid, rsp_tuser[0]);
         mismatches++;
      end
      if (rsp_tlast !== want.run_last) begin
         $error("run_last: expected %0b, got %0b", want.run_last, rsp_tlast);
         mismatches++;
      end
      if (rsp_tuser[1] !== want.stream_done) begin
         $error("stream_done: expected %0b, got %0b", want.stream_done, rsp_tuser[1]);
         mismatches++;
      end
      if (rsp_tdata[39:8] !== want.bytes_written) begin
         $error("bytes_written: expected %0d, got %0d", want.bytes_written, rsp_tdata[39:8]);
         mismatches++;
      end
   endfunction

   // Code byte driver: hold each transfer until accepted, predict on acceptance.
   always @(posedge clock) begin
      if (reset) begin
         req_tvalid <= 1'b0;
      end else if (!req_tvalid || req_tready) begin
         if (req_tvalid) begin
            predict_text(req_tdata, req_tuser, req_tlast);
            items_taken++;
         end
         if (pending_codes.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
            next_code = pending_codes.pop_front();
            req_tvalid <= 1'b1;
            req_tdata  <= next_code.code;
            req_tuser  <= next_code.ss;
            req_tlast  <= next_code.se;
         end else begin
            req_tvalid <= 1'b0;
         end
      end
   end

   // Text monitor: check each transfer, stall at random.
   always @(posedge clock) begin
      if (reset) begin
         rsp_tready <= 1'b0;
      end else begin
         if (rsp_tvalid && rsp_tready) check_text();
         rsp_tready <= ($urandom_range(99) >= recv_stall_pct);
      end
   end

   task automatic csr_write(logic idx, logic [31:0] val);
      @(posedge clock);
      csr_valid <= 1'b1;
      csr_index <= idx;
      csr_data  <= val;
      @(posedge clock);
      while (!csr_ready) @(posedge clock);
      csr_valid <= 1'b0;
      if (idx == CSR_LENGTH_BITS) len_bits_cfg = val[2:0];
      else out_limit = val;
   endtask

   // Hold until every code byte is taken and every text result has come.
   task automatic wait_drained();
      @(posedge clock);
      while (items_taken != items_pushed || expected_text.size() != 0) @(posedge clock);
      repeat (8) @(posedge clock);
   endtask

   function automatic void push_code(logic [7:0] code, bit ss, bit se);
      code_item_type it;
      it.code = code;
      it.ss   = ss;
      it.se   = se;
      pending_codes.push_back(it);
      items_pushed++;
   endfunction

   // Build one run of units, well-formed unless cut drops its last byte; references mostly point back into fresh text.
   function automatic void gen_stream(int unsigned units, bit start, bit finish, bit cut);
      code_item_type burst[$];
      int unsigned   lb;
      int unsigned   n;
      int unsigned   len;
      int unsigned   off;
      int unsigned   back_dist;
      int unsigned   b;
      logic [7:0]    flag_byte;
      lb = eff_len_bits(len_bits_cfg);
      n  = ring_size(len_bits_cfg);
      if (start) begin
         gen_made = 0;
         gen_base = (n - (1 << lb) - 2) & (n - 1);
      end
      while (units != 0) begin
         flag_byte = 8'($urandom_range(255));
         burst.push_back('{flag_byte, 1'b0, 1'b0});
         for (b = 0; b < 8 && units != 0; b++) begin
            units--;
            if (flag_byte[b]) begin
               burst.push_back('{8'($urandom_range(255)), 1'b0, 1'b0});
               gen_made++;
            end else begin
               len = $urandom_range((1 << lb) + 2, 3);
               if (gen_made != 0 && $urandom_range(3) != 0) begin
                  back_dist = $urandom_range((gen_made < n) ? gen_made : n, 1);
                  off = (gen_base + gen_made - back_dist) & (n - 1);
               end else begin
                  off = $urandom & (n - 1);
               end
               burst.push_back('{off[7:0], 1'b0, 1'b0});
               burst.push_back('{8'(((off >> 8) << lb) | (len - 3)), 1'b0, 1'b0});
               gen_made += len;
            end
         end
      end
      // drop the tail so the last unit comes up short
      if (cut && burst.size() > 1) void'(burst.pop_back());
      burst[0].ss = start;
      if (finish) burst[burst.size() - 1].se = 1'b1;
      foreach (burst[i]) push_code(burst[i].code, burst[i].ss, burst[i].se);
   endfunction

   function automatic void noise_burst(int unsigned count);
      repeat (count) begin
         push_code(8'($urandom_range(255)), $urandom_range(39) == 0,
                   $urandom_range(7) == 0);
      end
   endfunction

   initial begin
      int unsigned ph;
      int unsigned phase_start;
      int unsigned roll;
      int unsigned send_plan[4];
      int unsigned recv_plan[4];
      send_plan = '{0, 60, 0, 27};
      recv_plan = '{0, 0, 60, 27};
      len_bits_cfg = 3'd4;
      out_limit    = 32'hFFFF_FFFF;
      clear_stream_model();
      repeat (7) @(posedge clock);
      reset <= 1'b0;

      // directed: literal extremes, overlapping copy, copy from offset zero, truncation
      push_code(8'h05, 1'b1, 1'b0);
      push_code(8'hFF, 1'b0, 1'b0);
      push_code(8'hEE, 1'b0, 1'b0);
      push_code(8'hFF, 1'b0, 1'b0);
      push_code(8'h00, 1'b0, 1'b0);
      push_code(8'h00, 1'b0, 1'b0);
      push_code(8'h00, 1'b0, 1'b0);
      push_code(8'h12, 1'b0, 1'b1);
      push_code(8'hA5, 1'b1, 1'b1);
      wait_drained();

      // wide offsets with the longest copy, stream ends on a reference
      csr_write(CSR_LENGTH_BITS, 32'd5);
      push_code(8'h00, 1'b1, 1'b0);
      push_code(8'hDE, 1'b0, 1'b0);
      push_code(8'hFF, 1'b0, 1'b0);
      push_code(8'h10, 1'b0, 1'b0);
      push_code(8'hE0, 1'b0, 1'b1);
      wait_drained();

      // output limit reached, then an ignored byte; out-of-range length width
      csr_write(CSR_OUTPUT_LIMIT, 32'd5);
      csr_write(CSR_LENGTH_BITS, 32'd7);
      push_code(8'hFF, 1'b1, 1'b0);
      push_code(8'h11, 1'b0, 1'b0);
      push_code(8'h22, 1'b0, 1'b0);
      push_code(8'h33, 1'b0, 1'b0);
      push_code(8'h44, 1'b0, 1'b0);
      push_code(8'h55, 1'b0, 1'b0);
      push_code(8'h66, 1'b0, 1'b0);
      wait_drained();

      // raising the limit leaves the stop in place until a new stream
      csr_write(CSR_OUTPUT_LIMIT, 32'd100);
      push_code(8'h77, 1'b0, 1'b0);
      push_code(8'h01, 1'b1, 1'b0);
      push_code(8'h3C, 1'b0, 1'b1);
      wait_drained();

      csr_write(CSR_OUTPUT_LIMIT, 32'd0);
      csr_write(CSR_LENGTH_BITS, 32'd0);
      push_code(8'h88, 1'b1, 1'b0);
      push_code(8'h99, 1'b0, 1'b1);
      wait_drained();

      // random phases, each under one register setting and one idle pattern
      for (ph = 0; ph < 8; ph++) begin
         send_idle_pct  = send_plan[ph % 4];
         recv_stall_pct = recv_plan[ph % 4];
         csr_write(CSR_LENGTH_BITS, ($urandom_range(9) < 8) ? 32'(4 + $urandom_range(1))
                                                            : 32'($urandom_range(7)));
         roll = $urandom_range(9);
         if (roll < 6) csr_write(CSR_OUTPUT_LIMIT, 32'hFFFF_FFFF);
         else if (roll < 9) csr_write(CSR_OUTPUT_LIMIT, 32'($urandom_range(120, 8)));
         else csr_write(CSR_OUTPUT_LIMIT, $urandom);
         phase_start = items_pushed;
         while (items_pushed - phase_start < 40) begin
            roll = $urandom_range(9);
            if (roll < 7) begin
               gen_stream($urandom_range(20, 4), $urandom_range(7) != 0,
                          $urandom_range(7) != 0, 1'b0);
            end else if (roll < 8) begin
               gen_stream($urandom_range(12, 2), 1'b1, 1'b1, 1'b1);
            end else begin
               noise_burst($urandom_range(8, 2));
            end
            // in phase 3, pause the sender after every burst past mid-phase until all text is back
            if (ph == 3 && items_pushed - phase_start >= 26 && phase_start != 0) begin
               wait_drained();
               phase_start = 0 - (items_pushed - phase_start);
               phase_start = items_pushed + phase_start;
            end
         end
         wait_drained();
      end

      repeat (100) @(posedge clock);
      if (mismatches == 0) begin
         $display("[ OK ] regression clean");
      end else begin
         $display("[FAIL] regression broken");
      end
      $finish;
   end

   initial begin
      #8000000;
      $display("[FAIL] regression broken");
      $finish;
   end

endmodule

// ----- sim.f -----
design/lzwd_pkg.sv
design/lzwd_window_ram.sv
design/lzss_window_decoder.sv
sim/testbench.sv
